FILE: hw/rtl/pcx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types, constants and the per-byte run encoding step for the PCX
// run-length line encoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

    localparam logic [7:0] RUN_MARK    = 8'hC0;
    localparam logic [5:0] RUN_LIMIT   = 6'd63;
    localparam int         MAX_CODES   = 6;
    localparam int         CODE_IDX_W  = $clog2(MAX_CODES);
    localparam int         QUEUE_DEPTH = 2;
    localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Open run being counted
    typedef struct packed {
        logic       open;
        logic [7:0] value;
        logic [5:0] count;
    } t_run;

    // Result of encoding one byte: up to three code bytes and the new run
    typedef struct packed {
        t_run            run;
        logic [1:0]      n;
        logic [2:0][7:0] bytes;
    } t_enc;

    // One queue entry: the code bytes caused by one input transaction
    typedef struct packed {
        logic [MAX_CODES-1:0][7:0] bytes;
        logic [CODE_IDX_W-1:0]     cnt;
        logic                      line_end;
    } t_cmd;

    function automatic logic [7:0] run_header(t_run run);
        return RUN_MARK | {2'b00, run.count};
    endfunction

    function automatic t_enc enc_byte(t_run run, logic [7:0] b, logic next_eq);
        t_enc res;
        res.run   = run;
        res.n     = 2'd0;
        res.bytes = '0;
        if (run.open && (b == run.value) && (run.count < RUN_LIMIT)) begin
            res.run.count = run.count + 6'd1;
        end else begin
            if (run.open) begin
                res.bytes[0]  = run_header(run);
                res.bytes[1]  = run.value;
                res.n         = 2'd2;
                res.run.open  = 1'b0;
                res.run.count = 6'd0;
            end
            if (next_eq || (b >= RUN_MARK)) begin
                res.run.open  = 1'b1;
                res.run.value = b;
                res.run.count = 6'd1;
            end else begin
                res.bytes[res.n] = b;
                res.n            = res.n + 2'd1;
            end
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/pcx_rle_line_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_line_encoder
// PCX run-length encoder for one line of bytes at a time.
//
// Input channel (i_valid / o_ready): one line byte per transaction, with
// i_line_end set on the last byte of the line. Output channel (o_valid /
// i_ready): one code byte per transaction - run header, run value or literal.
// o_item_done marks the last code byte caused by an input transaction and
// o_line_done the final code byte of the line. A transaction that only holds
// its byte or extends a run causes no code byte.
//
// Each byte is held until the next one arrives as lookahead, so its code
// bytes follow the next input transaction. The code bytes of a transaction
// are registered in the queue and then in the output register. The output
// side moves one code byte per cycle while i_ready does not stall it; an
// input transaction yields zero to six bytes (two for a stream of literals
// of 0xC0 or more), so sustained throughput is one transaction per cycle at
// most, less when its code bytes back up behind the single output register. A
// two-entry queue lets input be taken while output stalls; o_ready drops only
// when that queue is full. Reset clears the held byte, the run state, the queue and o_valid.
// ----------------------------------------------------------------------------
module pcx_rle_line_encoder import pcx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_line_byte,
    input  logic       i_line_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_code_byte,
    output logic       o_item_done,
    output logic       o_line_done
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_out;

    pcx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_line_byte (i_line_byte),
        .i_line_end  (i_line_end),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in)
    );

    pcx_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_cmd   (q_out)
    );

    pcx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_out),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_byte (o_code_byte),
        .o_item_done (o_item_done),
        .o_line_done (o_line_done)
    );

endmodule

FILE: hw/rtl/pcx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_front
// Accepts line bytes, keeps the lookahead byte and run state, and turns each
// transaction into a queue entry listing its code bytes.
// ----------------------------------------------------------------------------
module pcx_front import pcx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_line_byte,
    input  logic       i_line_end,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    logic       r_held_valid;
    logic [7:0] r_held_byte;
    t_run       r_run;

    logic       n_held_valid;
    logic [7:0] n_held_byte;
    t_run       n_run;

    t_enc                  enc_a;
    t_enc                  enc_b;
    t_cmd                  cmd;
    logic                  accept;
    logic [CODE_IDX_W-1:0] k;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        // held byte first, with the incoming byte as lookahead
        if (r_held_valid) begin
            enc_a = enc_byte(r_run, r_held_byte, r_held_byte == i_line_byte);
        end else begin
            enc_a       = '0;
            enc_a.run   = r_run;
        end
        // last byte of a line sees an unequal lookahead
        if (i_line_end) begin
            enc_b = enc_byte(enc_a.run, i_line_byte, 1'b0);
        end else begin
            enc_b     = '0;
            enc_b.run = enc_a.run;
        end

        cmd          = '0;
        cmd.line_end = i_line_end;
        k            = '0;
        for (int i = 0; i < 3; i++) begin
            if (i < int'(enc_a.n)) begin
                cmd.bytes[k] = enc_a.bytes[i];
                k            = k + 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (i < int'(enc_b.n)) begin
                cmd.bytes[k] = enc_b.bytes[i];
                k            = k + 1'b1;
            end
        end
        // flush the open run at end of line
        if (i_line_end && enc_b.run.open) begin
            cmd.bytes[k] = run_header(enc_b.run);
            k            = k + 1'b1;
            cmd.bytes[k] = enc_b.run.value;
            k            = k + 1'b1;
        end
        cmd.cnt = k;

        if (i_line_end) begin
            n_held_valid = 1'b0;
            n_held_byte  = 8'd0;
            n_run        = '0;
        end else begin
            n_held_valid = 1'b1;
            n_held_byte  = i_line_byte;
            n_run        = enc_a.run;
        end
    end

    assign o_q_cmd  = cmd;
    assign o_q_push = accept && (cmd.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_byte  <= 8'd0;
            r_run        <= '0;
        end else if (accept) begin
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
            r_run        <= n_run;
        end
    end

endmodule

FILE: hw/rtl/pcx_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_cmd_queue
// Short register queue of code-byte entries between front and back.
// ----------------------------------------------------------------------------
module pcx_cmd_queue import pcx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

FILE: hw/rtl/pcx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_back
// Walks the head queue entry into the output register one code byte per
// cycle unless stalled, marking the last byte of each transaction and line.
// ----------------------------------------------------------------------------
module pcx_back import pcx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_code_byte,
    output logic       o_item_done,
    output logic       o_line_done
);

    logic [CODE_IDX_W-1:0] r_idx;
    logic                  r_valid;
    logic [7:0]            r_code;
    logic                  r_item_done;
    logic                  r_line_done;

    logic load;
    logic last;

    assign load    = (!r_valid || i_ready) && !i_q_empty;
    assign last    = (r_idx == i_q_cmd.cnt - 1'b1);
    assign o_q_pop = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code      <= i_q_cmd.bytes[r_idx];
            r_item_done <= last;
            r_line_done <= last && i_q_cmd.line_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_code_byte = r_code;
    assign o_item_done = r_item_done;
    assign o_line_done = r_line_done;

endmodule

FILE: hw/rtl/pcx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_checker
// Port-level checks for the PCX run-length line encoder, bound to the top.
// ----------------------------------------------------------------------------
module pcx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_code_byte,
    input logic       o_item_done,
    input logic       o_line_done
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_code_byte)
            && $stable(o_item_done) && $stable(o_line_done)))
        else $error("stalled output transaction changed");

    // end of line is always also end of a transaction's codes
    a_line_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_done) |-> o_item_done)
        else $error("line_done without item_done");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // handshake outputs and a valid payload are always known
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_ready})
            && (!o_valid || !$isunknown({o_code_byte, o_item_done, o_line_done})))
        else $error("unknown value on output ports");

endmodule

bind pcx_rle_line_encoder pcx_checker u_pcx_checker (.*);
